/* design/sdes_pkg.sv */
package sdes_pkg;

    localparam int KEY_W  = 10;
    localparam int BLK_W  = 8;
    localparam int HALF_W = 4;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CIPHER_KEY  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_INIT_VECTOR = 2'd2;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef struct packed {
        logic [BLK_W-1:0] k1;
        logic [BLK_W-1:0] k2;
    } subkeys_t;

    // S-boxes indexed by {row, col}
    localparam logic [1:0] SBOX0 [0:15] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] SBOX1 [0:15] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic logic [BLK_W-1:0] perm_ip(input logic [BLK_W-1:0] v);
        return {v[1], v[5], v[2], v[0], v[3], v[7], v[4], v[6]};
    endfunction

    function automatic logic [BLK_W-1:0] perm_ipinv(input logic [BLK_W-1:0] v);
        return {v[2], v[0], v[6], v[1], v[3], v[5], v[7], v[4]};
    endfunction

    function automatic logic [BLK_W-1:0] perm_ep(input logic [HALF_W-1:0] v);
        return {v[0], v[1], v[3], v[2], v[3], v[2], v[0], v[1]};
    endfunction

    function automatic logic [KEY_W-1:0] perm_p10(input logic [KEY_W-1:0] v);
        return {v[4], v[7], v[2], v[6], v[3], v[9], v[0], v[8], v[1], v[5]};
    endfunction

    function automatic logic [BLK_W-1:0] perm_p8(input logic [KEY_W-1:0] v);
        return {v[0], v[2], v[1], v[3], v[4], v[9], v[6], v[8]};
    endfunction

endpackage

/* design/sdes_cbc_byte_cipher.sv */
// Byte-wide S-DES cipher in CBC mode. One 8-bit block in, one 8-bit block out.
// Write direction (index 0), 10-bit key (index 1) and IV (index 2) on the cfg
// port while no transaction is in flight; other indexes are ignored. Set
// first_block to restart the chain from the IV. A new input transaction can be
// taken every cycle while the result register is not stalled. Each block passes
// an input register, then a result register, the two Feistel rounds between them
// combinational. The chain register is fed the result, or the input on decrypt.
module sdes_cbc_byte_cipher
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sdes_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sdes_pkg::KEY_W-1:0]   cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sdes_pkg::BLK_W-1:0]   data_in,
    input  logic                         first_block,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sdes_pkg::BLK_W-1:0]   data_out
);

    logic                       direction_reg;
    logic [sdes_pkg::KEY_W-1:0] cipher_key_reg;
    logic [sdes_pkg::BLK_W-1:0] init_vector_reg;
    logic [sdes_pkg::BLK_W-1:0] chain_reg;
    logic [sdes_pkg::BLK_W-1:0] chain_next;

    logic                       s1_valid_reg;
    logic [sdes_pkg::BLK_W-1:0] s1_data_reg;
    logic                       s1_first_reg;

    logic                       out_valid_reg;
    logic [sdes_pkg::BLK_W-1:0] out_data_reg;
    logic [sdes_pkg::BLK_W-1:0] out_data_next;

    sdes_pkg::subkeys_t         subkeys;
    logic [sdes_pkg::BLK_W-1:0] chain_cur;
    logic [sdes_pkg::BLK_W-1:0] f_in;
    logic [sdes_pkg::BLK_W-1:0] f_out;
    logic [sdes_pkg::BLK_W-1:0] key_a;
    logic [sdes_pkg::BLK_W-1:0] key_b;
    logic                       advance;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= sdes_pkg::DIR_ENCRYPT;
            cipher_key_reg  <= '0;
            init_vector_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdes_pkg::CFG_DIRECTION:   direction_reg   <= cfg_data[0];
                sdes_pkg::CFG_CIPHER_KEY:  cipher_key_reg  <= cfg_data;
                sdes_pkg::CFG_INIT_VECTOR: init_vector_reg <= cfg_data[sdes_pkg::BLK_W-1:0];
                default: ;
            endcase
        end
    end

    sdes_key_sched u_key_sched
    (
        .cipher_key (cipher_key_reg),
        .subkeys    (subkeys)
    );

    always_comb
    begin
        chain_cur = s1_first_reg ? init_vector_reg : chain_reg;
        if (direction_reg == sdes_pkg::DIR_DECRYPT)
        begin
            key_a = subkeys.k2;
            key_b = subkeys.k1;
            f_in  = s1_data_reg;
        end
        else
        begin
            key_a = subkeys.k1;
            key_b = subkeys.k2;
            f_in  = s1_data_reg ^ chain_cur;
        end
    end

    sdes_feistel u_feistel
    (
        .block_in  (f_in),
        .key_a     (key_a),
        .key_b     (key_b),
        .block_out (f_out)
    );

    always_comb
    begin
        if (direction_reg == sdes_pkg::DIR_DECRYPT)
        begin
            out_data_next = f_out ^ chain_cur;
            chain_next    = s1_data_reg;
        end
        else
        begin
            out_data_next = f_out;
            chain_next    = f_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    chain_reg <= chain_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg  <= data_in;
            s1_first_reg <= first_block;
        end
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* design/sdes_key_sched.sv */
module sdes_key_sched
(
    input  logic [sdes_pkg::KEY_W-1:0] cipher_key,
    output sdes_pkg::subkeys_t         subkeys
);

    logic [sdes_pkg::KEY_W-1:0] p10;
    logic [sdes_pkg::KEY_W-1:0] ls1;
    logic [sdes_pkg::KEY_W-1:0] ls2;

    assign p10 = sdes_pkg::perm_p10(cipher_key);

    // 5-bit half rotations: LS-1 then a further LS-2
    assign ls1 = {p10[8:5], p10[9], p10[3:0], p10[4]};
    assign ls2 = {ls1[7:5], ls1[9:8], ls1[2:0], ls1[4:3]};

    assign subkeys.k1 = sdes_pkg::perm_p8(ls1);
    assign subkeys.k2 = sdes_pkg::perm_p8(ls2);

endmodule

/* design/sdes_feistel.sv */
module sdes_feistel
(
    input  logic [sdes_pkg::BLK_W-1:0] block_in,
    input  logic [sdes_pkg::BLK_W-1:0] key_a,
    input  logic [sdes_pkg::BLK_W-1:0] key_b,
    output logic [sdes_pkg::BLK_W-1:0] block_out
);

    function automatic logic [sdes_pkg::HALF_W-1:0] round_f(
        input logic [sdes_pkg::HALF_W-1:0] r,
        input logic [sdes_pkg::BLK_W-1:0]  sk
    );
        logic [sdes_pkg::BLK_W-1:0] e;
        logic [1:0]                 a;
        logic [1:0]                 b;
        e = sdes_pkg::perm_ep(r) ^ sk;
        a = sdes_pkg::SBOX0[{e[7], e[4], e[6], e[5]}];
        b = sdes_pkg::SBOX1[{e[3], e[0], e[2], e[1]}];
        return {a[1], b[1], b[0], a[0]};
    endfunction

    logic [sdes_pkg::BLK_W-1:0]  ip;
    logic [sdes_pkg::HALF_W-1:0] r1;
    logic [sdes_pkg::HALF_W-1:0] hi;

    assign ip = sdes_pkg::perm_ip(block_in);
    assign r1 = ip[7:4] ^ round_f(ip[3:0], key_a);
    assign hi = ip[3:0] ^ round_f(r1, key_b);
    assign block_out = sdes_pkg::perm_ipinv({hi, r1});

endmodule

/* design/sdes_checker.sv */
module sdes_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [sdes_pkg::BLK_W-1:0] data_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out))
        else $error("result changed or dropped while stalled");

    // input only backs up when the result register is full and stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // every new result comes from an earlier accepted input transaction
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching input transaction");

endmodule

bind sdes_cbc_byte_cipher sdes_checker u_sdes_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out)
);

/* verif/tb_sdes_cbc_byte_cipher.sv */
`timescale 1ns / 100ps

module tb_sdes_cbc_byte_cipher;

    localparam logic [sdes_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;

    // source bit per output bit, entry for output bit j at [4*j +: 4]
    localparam logic [39:0] IP_MAP    = {8'h00, 4'd1, 4'd5, 4'd2, 4'd0,
                                         4'd3, 4'd7, 4'd4, 4'd6};
    localparam logic [39:0] IPINV_MAP = {8'h00, 4'd2, 4'd0, 4'd6, 4'd1,
                                         4'd3, 4'd5, 4'd7, 4'd4};
    localparam logic [39:0] EP_MAP    = {8'h00, 4'd0, 4'd1, 4'd3, 4'd2,
                                         4'd3, 4'd2, 4'd0, 4'd1};
    localparam logic [39:0] P10_MAP   = {4'd4, 4'd7, 4'd2, 4'd6, 4'd3,
                                         4'd9, 4'd0, 4'd8, 4'd1, 4'd5};
    localparam logic [39:0] P8_MAP    = {8'h00, 4'd0, 4'd2, 4'd1, 4'd3,
                                         4'd4, 4'd9, 4'd6, 4'd8};

    localparam logic [0:15][1:0] SBOX_A = {2'd1, 2'd0, 2'd3, 2'd2,
                                           2'd3, 2'd2, 2'd1, 2'd0,
                                           2'd0, 2'd2, 2'd1, 2'd3,
                                           2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [0:15][1:0] SBOX_B = {2'd0, 2'd1, 2'd2, 2'd3,
                                           2'd2, 2'd0, 2'd1, 2'd3,
                                           2'd3, 2'd0, 2'd1, 2'd0,
                                           2'd2, 2'd1, 2'd0, 2'd3};

    typedef struct packed {
        logic [sdes_pkg::BLK_W-1:0] data;
        logic                       first;
    } byte_item_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [sdes_pkg::IDX_W-1:0] cfg_index = '0;
    logic [sdes_pkg::KEY_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [sdes_pkg::BLK_W-1:0] data_in = '0;
    logic                       first_block = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [sdes_pkg::BLK_W-1:0] data_out;

    byte_item_t                 item_q[$];
    logic [sdes_pkg::BLK_W-1:0] cipher_q[$];

    logic                       dir_cfg = sdes_pkg::DIR_ENCRYPT;
    logic [sdes_pkg::KEY_W-1:0] key_cfg = '0;
    logic [sdes_pkg::BLK_W-1:0] iv_cfg = '0;
    logic [sdes_pkg::BLK_W-1:0] chain_reg = '0;

    int                         fail_count = 0;
    int                         sent_count = 0;
    int                         done_count = 0;
    int                         burst_left = 0;
    int                         gap_left = 0;
    logic [15:0]                ready_mask = 16'hFFFF;
    int unsigned                ready_pos = 0;

    sdes_cbc_byte_cipher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_in     (data_in),
        .first_block (first_block),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [9:0] remap_bits(input logic [9:0] v, input logic [39:0] map,
                                              input int n);
        logic [9:0] r;
        r = '0;
        for (int j = 0; j < n; j++)
            r[j] = v[map[4*j +: 4]];
        return r;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] x, input int k);
        logic [9:0] w;
        w = {x, x} << k;
        return w[9:5];
    endfunction

    function automatic logic [3:0] round_mix(input logic [3:0] half, input logic [7:0] sk);
        logic [9:0] ex;
        logic [7:0] e;
        logic [1:0] a;
        logic [1:0] b;
        ex = remap_bits({6'd0, half}, EP_MAP, 8);
        e = ex[7:0] ^ sk;
        a = SBOX_A[{e[7], e[4], e[6], e[5]}];
        b = SBOX_B[{e[3], e[0], e[2], e[1]}];
        return {a[1], b[1], b[0], a[0]};
    endfunction

    function automatic logic [7:0] sdes_core(input logic [7:0] blk, input logic [7:0] ka,
                                             input logic [7:0] kb);
        logic [9:0] ip;
        logic [9:0] res;
        logic [3:0] r1;
        logic [3:0] hi;
        ip = remap_bits({2'b00, blk}, IP_MAP, 8);
        r1 = ip[7:4] ^ round_mix(ip[3:0], ka);
        hi = ip[3:0] ^ round_mix(r1, kb);
        res = remap_bits({2'b00, hi, r1}, IPINV_MAP, 8);
        return res[7:0];
    endfunction

    task automatic predict_block(input logic [7:0] din, input logic first);
        logic [9:0] p;
        logic [9:0] s1;
        logic [9:0] s2;
        logic [9:0] t1;
        logic [9:0] t2;
        logic [7:0] res;
        if (first)
            chain_reg = iv_cfg;
        p = remap_bits(key_cfg, P10_MAP, 10);
        s1 = {rotl5(p[9:5], 1), rotl5(p[4:0], 1)};
        s2 = {rotl5(s1[9:5], 2), rotl5(s1[4:0], 2)};
        t1 = remap_bits(s1, P8_MAP, 8);
        t2 = remap_bits(s2, P8_MAP, 8);
        if (dir_cfg == sdes_pkg::DIR_ENCRYPT)
        begin
            res = sdes_core(din ^ chain_reg, t1[7:0], t2[7:0]);
            chain_reg = res;
        end
        else
        begin
            res = sdes_core(din, t2[7:0], t1[7:0]) ^ chain_reg;
            chain_reg = din;
        end
        cipher_q.push_back(res);
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
            $display("%0t ERROR %s", $time, msg);
        fail_count++;
    endtask

    // predictor update and output check
    always @(posedge clk)
    begin : scoreboard
        logic [sdes_pkg::BLK_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sdes_pkg::CFG_DIRECTION:   dir_cfg = cfg_data[0];
                    sdes_pkg::CFG_CIPHER_KEY:  key_cfg = cfg_data;
                    sdes_pkg::CFG_INIT_VECTOR: iv_cfg = cfg_data[sdes_pkg::BLK_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_block(data_in, first_block);
            if (out_valid && out_ready)
            begin
                done_count++;
                if (cipher_q.size() == 0)
                    report_mismatch($sformatf("unexpected transaction data_out=%02h", data_out));
                else
                begin
                    want = cipher_q.pop_front();
                    if (data_out !== want)
                        report_mismatch($sformatf("data_out got %02h exp %02h", data_out, want));
                end
            end
        end
    end

    always @(posedge clk)
    begin : drive_in
        byte_item_t nxt;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                nxt = item_q.pop_front();
                in_valid <= 1'b1;
                data_in <= nxt.data;
                first_block <= nxt.first;
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 31);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (ready_pos == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_mask = 16'hFFFF;
                1: ready_mask = 16'($urandom) | 16'h0101;
                2: ready_mask = 16'h8888;
                default: ready_mask = 16'h7F3F;
            endcase
        end
        out_ready <= rst_n && ready_mask[ready_pos[3:0]];
        ready_pos = (ready_pos + 1) % 64;
    end

    task automatic write_reg(input logic [sdes_pkg::IDX_W-1:0] idx,
                             input logic [sdes_pkg::KEY_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_item(input logic [7:0] din, input logic first);
        byte_item_t it;
        it.data = din;
        it.first = first;
        item_q.push_back(it);
        sent_count++;
    endtask

    task automatic wait_idle();
        while (done_count < sent_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [sdes_pkg::KEY_W-1:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : stimulus
        int count;
        int len;
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // chain from reset, no message start
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h5A, 1'b0);
        wait_idle();

        write_reg(sdes_pkg::CFG_CIPHER_KEY, 10'h3FF);
        write_reg(sdes_pkg::CFG_INIT_VECTOR, 10'h3FF);
        write_reg(sdes_pkg::CFG_DIRECTION, {9'h1FF, sdes_pkg::DIR_ENCRYPT});
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'hA5, 1'b0);
        wait_idle();

        // new IV mid-message leaves the chain alone until a restart
        write_reg(sdes_pkg::CFG_INIT_VECTOR, 10'h300);
        push_item(8'h3C, 1'b0);
        push_item(8'hC3, 1'b1);
        wait_idle();

        // direction flip mid-message
        write_reg(sdes_pkg::CFG_DIRECTION, {9'h000, sdes_pkg::DIR_DECRYPT});
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h81, 1'b1);
        push_item(8'h7E, 1'b0);
        wait_idle();

        write_reg(CFG_UNUSED, 10'h3FF);
        write_reg(sdes_pkg::CFG_CIPHER_KEY, 10'h000);
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b0);
        wait_idle();

        write_reg(sdes_pkg::CFG_DIRECTION, {9'h000, sdes_pkg::DIR_ENCRYPT});
        push_item(8'h55, 1'b1);
        push_item(8'hAA, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            if ($urandom_range(0, 1) == 0)
                write_reg(sdes_pkg::CFG_CIPHER_KEY, pick_reg_value());
            if ($urandom_range(0, 1) == 0)
                write_reg(sdes_pkg::CFG_INIT_VECTOR, pick_reg_value());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, pick_reg_value());
            write_reg(sdes_pkg::CFG_DIRECTION,
                      (ph % 2 == 0) ? {9'h000, sdes_pkg::DIR_ENCRYPT}
                                    : {9'($urandom_range(0, 511)), sdes_pkg::DIR_DECRYPT});
            count = 0;
            target = $urandom_range(125, 145);
            while (count < target)
            begin
                len = $urandom_range(1, 24);
                if ($urandom_range(0, 6) != 0)
                begin
                    push_item(pick_byte(), 1'b1);
                    for (int i = 1; i < len; i++)
                        push_item(pick_byte(), 1'b0);
                end
                else
                begin
                    for (int i = 0; i < len; i++)
                        push_item(pick_byte(), 1'($urandom_range(0, 1)));
                end
                count += len;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
